@@ rtl/msmon_pkg.sv @@
// ----------------------------------------------------------------------------
// msmon_pkg
// Shared widths, register codes, queue item and state types of the
// multi-sensor statistics monitor.
// ----------------------------------------------------------------------------
package msmon_pkg;

   localparam int SAMPLE_BITS    = 10;
   localparam int COUNT_BITS     = 16;
   localparam int SUM_BITS       = SAMPLE_BITS + COUNT_BITS;
   localparam int QUOT_BITS      = SAMPLE_BITS;
   localparam int INDEX_BITS     = 2;
   localparam int TOTAL_BITS     = 3;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX        = '1;
   localparam logic [COUNT_BITS-1:0]  COUNT_MAX         = '1;
   localparam logic [TOTAL_BITS-1:0]  TOTAL_MAX         = '1;
   localparam logic [COUNT_BITS-1:0]  AVG_COUNT_RESET   = COUNT_BITS'(16);
   localparam logic [TOTAL_BITS-1:0]  ALARM_LEVEL_RESET = TOTAL_BITS'(2);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_LIMIT_ZERO    = 3'd0,
      CSR_LIMIT_ONE     = 3'd1,
      CSR_LIMIT_TWO     = 3'd2,
      CSR_LIMIT_THREE   = 3'd3,
      CSR_AVERAGE_COUNT = 3'd4,
      CSR_ALARM_LEVEL   = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [INDEX_BITS-1:0]  sensor_index;
      logic                   in_range;
      logic                   sample_valid;
      logic [SAMPLE_BITS-1:0] sample;
      logic                   clear_average;
      logic                   clear_max;
      logic                   clear_min;
   } item_type;

   typedef struct packed {
      logic     avail;
      item_type item;
   } queue_head_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_REPORT
   } back_state_type;

endpackage

@@ rtl/msmon_front.sv @@
// ----------------------------------------------------------------------------
// msmon_front
// Accepts request transactions, checks the sensor index and holds them in a
// two-entry queue until the back end takes them.
// ----------------------------------------------------------------------------
module msmon_front #(
   parameter int NUM_SENSORS = 4
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_push,
   output logic                                   req_full,
   input  logic [msmon_pkg::INDEX_BITS-1:0]       req_sensor_index,
   input  logic                                   req_sample_valid,
   input  logic [msmon_pkg::SAMPLE_BITS-1:0]      req_sample,
   input  logic                                   req_clear_average,
   input  logic                                   req_clear_max,
   input  logic                                   req_clear_min,
   output msmon_pkg::queue_head_type              head,
   input  logic                                   head_pop
);

   localparam int DEPTH = 2;

   msmon_pkg::item_type mem_ff [DEPTH];
   msmon_pkg::item_type new_item;
   logic [1:0]          fill_ff, fill_in;
   logic                wr_ptr_ff, wr_ptr_in;
   logic                rd_ptr_ff, rd_ptr_in;
   logic                push_ok;
   logic                pop_ok;

   always_comb begin
      new_item.sensor_index  = req_sensor_index;
      new_item.in_range      = int'(req_sensor_index) < NUM_SENSORS;
      new_item.sample_valid  = req_sample_valid;
      new_item.sample        = req_sample;
      new_item.clear_average = req_clear_average;
      new_item.clear_max     = req_clear_max;
      new_item.clear_min     = req_clear_min;
   end

   assign req_full = fill_ff == 2'(DEPTH);
   assign push_ok  = req_push && !req_full;
   assign pop_ok   = head_pop && (fill_ff != 2'd0);

   assign head.avail = fill_ff != 2'd0;
   assign head.item  = mem_ff[rd_ptr_ff];

   always_comb begin
      fill_in   = fill_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push_ok) begin
         wr_ptr_in = !wr_ptr_ff;
      end
      if (pop_ok) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      case ({push_ok, pop_ok})
         2'b10:   fill_in = fill_ff + 2'd1;
         2'b01:   fill_in = fill_ff - 2'd1;
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         fill_ff   <= fill_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

@@ rtl/msmon_divider.sv @@
// ----------------------------------------------------------------------------
// msmon_divider
// Restoring divider, one quotient bit per cycle. The quotient is known to fit
// in the sample width, so only that many steps are run.
// ----------------------------------------------------------------------------
module msmon_divider (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [msmon_pkg::SUM_BITS-1:0]      dividend,
   input  logic [msmon_pkg::COUNT_BITS-1:0]    divisor,
   output logic                                done,
   output logic [msmon_pkg::QUOT_BITS-1:0]     quotient
);

   localparam int STEP_BITS = $clog2(msmon_pkg::QUOT_BITS);

   logic [msmon_pkg::SUM_BITS-1:0]  rem_ff, rem_in;
   logic [msmon_pkg::SUM_BITS-1:0]  dsh_ff, dsh_in;
   logic [msmon_pkg::QUOT_BITS-1:0] quot_ff, quot_in;
   logic [STEP_BITS-1:0]            step_ff, step_in;
   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic                            fits;

   assign fits = rem_ff >= dsh_ff;

   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quot_in = quot_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = dividend;
         dsh_in  = msmon_pkg::SUM_BITS'({divisor, {(msmon_pkg::QUOT_BITS-1){1'b0}}});
         quot_in = '0;
         step_in = STEP_BITS'(msmon_pkg::QUOT_BITS - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - dsh_ff;
         end
         quot_in = {quot_ff[msmon_pkg::QUOT_BITS-2:0], fits};
         dsh_in  = dsh_ff >> 1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quot_ff <= quot_in;
      step_ff <= step_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

@@ rtl/msmon_back.sv @@
// ----------------------------------------------------------------------------
// msmon_back
// Holds the per-sensor statistics and the control registers, applies one
// queued transaction, runs the average division and drives the result register.
// ----------------------------------------------------------------------------
module msmon_back #(
   parameter int NUM_SENSORS = 4
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write_enable,
   input  logic [msmon_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [msmon_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   input  msmon_pkg::queue_head_type              head,
   output logic                                   head_pop,
   output logic                                   rsp_empty,
   input  logic                                   rsp_pop,
   output logic [msmon_pkg::SAMPLE_BITS-1:0]      rsp_average,
   output logic [msmon_pkg::SAMPLE_BITS-1:0]      rsp_max_seen,
   output logic [msmon_pkg::SAMPLE_BITS-1:0]      rsp_min_seen,
   output logic                                   rsp_new_average,
   output logic                                   rsp_over_limit,
   output logic [msmon_pkg::TOTAL_BITS-1:0]       rsp_sensors_over,
   output logic                                   rsp_alarm
);

   localparam int IDX_BITS = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;

   // control registers
   logic [msmon_pkg::SAMPLE_BITS-1:0] limit_ff [NUM_SENSORS];
   logic [msmon_pkg::COUNT_BITS-1:0]  avg_count_ff;
   logic [msmon_pkg::TOTAL_BITS-1:0]  alarm_level_ff;

   // per-sensor statistics
   logic [msmon_pkg::COUNT_BITS-1:0]  count_ff [NUM_SENSORS];
   logic [msmon_pkg::SUM_BITS-1:0]    sum_ff   [NUM_SENSORS];
   logic [msmon_pkg::SAMPLE_BITS-1:0] max_ff   [NUM_SENSORS];
   logic [msmon_pkg::SAMPLE_BITS-1:0] min_ff   [NUM_SENSORS];
   logic                              over_ff  [NUM_SENSORS];
   logic                              ready_ff [NUM_SENSORS];
   logic [msmon_pkg::TOTAL_BITS-1:0]  total_ff;

   msmon_pkg::back_state_type state_ff, state_in;
   msmon_pkg::item_type       item;
   logic [IDX_BITS-1:0]       sel;
   logic                      apply;
   logic                      dispatch;
   logic                      load_out;
   logic                      out_free;

   logic [msmon_pkg::COUNT_BITS-1:0]  cnt_cur, cnt_upd;
   logic [msmon_pkg::SUM_BITS-1:0]    sum_cur, sum_upd;
   logic [msmon_pkg::SAMPLE_BITS-1:0] max_cur, max_upd;
   logic [msmon_pkg::SAMPLE_BITS-1:0] min_cur, min_upd;
   logic [msmon_pkg::SAMPLE_BITS-1:0] limit_cur;
   logic                              over_cur, over_upd;
   logic                              ready_cur, ready_upd;
   logic [msmon_pkg::TOTAL_BITS-1:0]  total_upd;

   // report values latched at dispatch
   logic [msmon_pkg::SAMPLE_BITS-1:0] rep_max_ff;
   logic [msmon_pkg::SAMPLE_BITS-1:0] rep_min_ff;
   logic                              rep_ready_ff;
   logic                              rep_over_ff;
   logic [msmon_pkg::TOTAL_BITS-1:0]  rep_total_ff;
   logic                              rep_alarm_ff;
   logic                              rep_zero_ff;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [msmon_pkg::SAMPLE_BITS-1:0] out_avg_ff;
   logic [msmon_pkg::SAMPLE_BITS-1:0] out_max_ff;
   logic [msmon_pkg::SAMPLE_BITS-1:0] out_min_ff;
   logic                              out_ready_ff;
   logic                              out_over_ff;
   logic [msmon_pkg::TOTAL_BITS-1:0]  out_total_ff;
   logic                              out_alarm_ff;

   logic                              div_done;
   logic [msmon_pkg::QUOT_BITS-1:0]   div_quot;

   assign item     = head.item;
   assign sel      = item.sensor_index[IDX_BITS-1:0];
   assign apply    = item.in_range && item.sample_valid;
   assign out_free = !rsp_valid_ff || rsp_pop;

   // --- configuration writes ---
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SENSORS; i++) begin
            limit_ff[i] <= msmon_pkg::SAMPLE_MAX;
         end
         avg_count_ff   <= msmon_pkg::AVG_COUNT_RESET;
         alarm_level_ff <= msmon_pkg::ALARM_LEVEL_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index) inside
            msmon_pkg::CSR_LIMIT_ZERO,
            msmon_pkg::CSR_LIMIT_ONE,
            msmon_pkg::CSR_LIMIT_TWO,
            msmon_pkg::CSR_LIMIT_THREE: begin
               if (int'(csr_index) < NUM_SENSORS) begin
                  limit_ff[csr_index[IDX_BITS-1:0]] <=
                     csr_wdata[msmon_pkg::SAMPLE_BITS-1:0];
               end
            end
            msmon_pkg::CSR_AVERAGE_COUNT: begin
               avg_count_ff <= csr_wdata[msmon_pkg::COUNT_BITS-1:0];
            end
            msmon_pkg::CSR_ALARM_LEVEL: begin
               alarm_level_ff <= csr_wdata[msmon_pkg::TOTAL_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // --- sample update of the selected sensor ---
   always_comb begin
      cnt_cur   = count_ff[sel];
      sum_cur   = sum_ff[sel];
      max_cur   = max_ff[sel];
      min_cur   = min_ff[sel];
      over_cur  = over_ff[sel];
      ready_cur = ready_ff[sel];
      limit_cur = limit_ff[sel];

      cnt_upd   = cnt_cur;
      sum_upd   = sum_cur;
      max_upd   = max_cur;
      min_upd   = min_cur;
      over_upd  = over_cur;
      ready_upd = ready_cur;
      total_upd = total_ff;
      if (apply) begin
         // saturated count freezes count and sum together
         if (cnt_cur != msmon_pkg::COUNT_MAX) begin
            cnt_upd = cnt_cur + 1'b1;
            sum_upd = sum_cur + msmon_pkg::SUM_BITS'(item.sample);
         end
         if (cnt_upd >= avg_count_ff) begin
            ready_upd = 1'b1;
         end
         // a sample equal to the limit keeps the flag
         if (item.sample > limit_cur && !over_cur) begin
            over_upd = 1'b1;
            if (total_ff != msmon_pkg::TOTAL_MAX) begin
               total_upd = total_ff + 1'b1;
            end
         end else if (item.sample < limit_cur && over_cur) begin
            over_upd = 1'b0;
            if (total_ff != '0) begin
               total_upd = total_ff - 1'b1;
            end
         end
         if (item.sample > max_cur) begin
            max_upd = item.sample;
         end
         if (item.sample < min_cur) begin
            min_upd = item.sample;
         end
      end
   end

   // --- sequencer ---
   always_comb begin : next_state
      state_in = state_ff;
      unique case (state_ff)
         msmon_pkg::ST_IDLE: begin
            if (head.avail) begin
               state_in = msmon_pkg::ST_DIVIDE;
            end
         end
         msmon_pkg::ST_DIVIDE: begin
            if (div_done) begin
               state_in = msmon_pkg::ST_REPORT;
            end
         end
         msmon_pkg::ST_REPORT: begin
            if (out_free) begin
               state_in = msmon_pkg::ST_IDLE;
            end
         end
         default: state_in = msmon_pkg::ST_IDLE;
      endcase
   end

   always_comb begin : state_outputs
      dispatch = 1'b0;
      load_out = 1'b0;
      unique case (state_ff)
         msmon_pkg::ST_IDLE:   dispatch = head.avail;
         msmon_pkg::ST_DIVIDE: dispatch = 1'b0;
         msmon_pkg::ST_REPORT: load_out = out_free;
         default:              dispatch = 1'b0;
      endcase
   end

   assign head_pop = dispatch;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= msmon_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // --- statistics state, clears land as the report is latched ---
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SENSORS; i++) begin
            count_ff[i] <= '0;
            sum_ff[i]   <= '0;
            max_ff[i]   <= '0;
            min_ff[i]   <= msmon_pkg::SAMPLE_MAX;
            over_ff[i]  <= 1'b0;
            ready_ff[i] <= 1'b0;
         end
         total_ff <= '0;
      end else if (dispatch && item.in_range) begin
         count_ff[sel] <= item.clear_average ? '0 : cnt_upd;
         sum_ff[sel]   <= item.clear_average ? '0 : sum_upd;
         ready_ff[sel] <= item.clear_average ? 1'b0 : ready_upd;
         max_ff[sel]   <= item.clear_max ? '0 : max_upd;
         min_ff[sel]   <= item.clear_min ? msmon_pkg::SAMPLE_MAX : min_upd;
         over_ff[sel]  <= over_upd;
         total_ff      <= total_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (dispatch) begin
         rep_max_ff   <= item.in_range ? max_upd : '0;
         rep_min_ff   <= item.in_range ? min_upd : '0;
         rep_ready_ff <= item.in_range && ready_upd;
         rep_over_ff  <= item.in_range && over_upd;
         rep_total_ff <= total_upd;
         rep_alarm_ff <= total_upd >= alarm_level_ff;
         rep_zero_ff  <= !item.in_range || (cnt_upd == '0);
      end
   end

   msmon_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (dispatch),
      .dividend (sum_upd),
      .divisor  (cnt_upd),
      .done     (div_done),
      .quotient (div_quot)
   );

   // --- result register ---
   assign rsp_valid_in = load_out || (rsp_valid_ff && !rsp_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_avg_ff   <= rep_zero_ff ? '0 : div_quot;
         out_max_ff   <= rep_max_ff;
         out_min_ff   <= rep_min_ff;
         out_ready_ff <= rep_ready_ff;
         out_over_ff  <= rep_over_ff;
         out_total_ff <= rep_total_ff;
         out_alarm_ff <= rep_alarm_ff;
      end
   end

   assign rsp_empty        = !rsp_valid_ff;
   assign rsp_average      = out_avg_ff;
   assign rsp_max_seen     = out_max_ff;
   assign rsp_min_seen     = out_min_ff;
   assign rsp_new_average  = out_ready_ff;
   assign rsp_over_limit   = out_over_ff;
   assign rsp_sensors_over = out_total_ff;
   assign rsp_alarm        = out_alarm_ff;

endmodule

@@ rtl/multi_sensor_stats_monitor_unit.sv @@
// ----------------------------------------------------------------------------
// multi_sensor_stats_monitor_unit
// Per-sensor running average, maximum, minimum and over-limit alarm monitor.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  req_      in         push / full          sensor index, sample, clear bits
//  rsp_      out        empty / pop          average, max, min, flags, count
//  csr_      in         write enable only    register index, write data
//
// an item passes through the input queue, where the sample and clears are
// applied as it leaves, then through the bit-serial divider, and is then reported.
// the back end takes no new item until the last one has been reported.
// reset is synchronous; it restores registers and statistics at once.
// a full result register stalls the back end; the queue then takes two pushes.
module multi_sensor_stats_monitor_unit #(
   parameter int NUM_SENSORS = 4
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_push,
   output logic                                   req_full,
   input  logic [msmon_pkg::INDEX_BITS-1:0]       req_sensor_index,
   input  logic                                   req_sample_valid,
   input  logic [msmon_pkg::SAMPLE_BITS-1:0]      req_sample,
   input  logic                                   req_clear_average,
   input  logic                                   req_clear_max,
   input  logic                                   req_clear_min,
   output logic                                   rsp_empty,
   input  logic                                   rsp_pop,
   output logic [msmon_pkg::SAMPLE_BITS-1:0]      rsp_average,
   output logic [msmon_pkg::SAMPLE_BITS-1:0]      rsp_max_seen,
   output logic [msmon_pkg::SAMPLE_BITS-1:0]      rsp_min_seen,
   output logic                                   rsp_new_average,
   output logic                                   rsp_over_limit,
   output logic [msmon_pkg::TOTAL_BITS-1:0]       rsp_sensors_over,
   output logic                                   rsp_alarm,
   input  logic                                   csr_write_enable,
   input  logic [msmon_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [msmon_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   msmon_pkg::queue_head_type head;
   logic                      head_pop;

   msmon_front #(
      .NUM_SENSORS (NUM_SENSORS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_sensor_index  (req_sensor_index),
      .req_sample_valid  (req_sample_valid),
      .req_sample        (req_sample),
      .req_clear_average (req_clear_average),
      .req_clear_max     (req_clear_max),
      .req_clear_min     (req_clear_min),
      .head              (head),
      .head_pop          (head_pop)
   );

   msmon_back #(
      .NUM_SENSORS (NUM_SENSORS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .head             (head),
      .head_pop         (head_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_average      (rsp_average),
      .rsp_max_seen     (rsp_max_seen),
      .rsp_min_seen     (rsp_min_seen),
      .rsp_new_average  (rsp_new_average),
      .rsp_over_limit   (rsp_over_limit),
      .rsp_sensors_over (rsp_sensors_over),
      .rsp_alarm        (rsp_alarm)
   );

endmodule

@@ rtl/msmon_checker.sv @@
// ----------------------------------------------------------------------------
// msmon_checker
// Port-level checks of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module msmon_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_empty,
   input logic                                rsp_pop,
   input logic [msmon_pkg::SAMPLE_BITS-1:0]   rsp_average,
   input logic [msmon_pkg::SAMPLE_BITS-1:0]   rsp_max_seen,
   input logic [msmon_pkg::SAMPLE_BITS-1:0]   rsp_min_seen,
   input logic                                rsp_over_limit,
   input logic [msmon_pkg::TOTAL_BITS-1:0]    rsp_sensors_over
);

   // no result can be waiting right after reset
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("result waiting after reset");

   // a waiting result that is not taken stays put
   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_average)
         && $stable(rsp_max_seen) && $stable(rsp_min_seen)))
      else $error("waiting result changed or vanished");

   // the named sensor being over limit means the shared count is nonzero
   a_over_counted: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_over_limit) |-> (rsp_sensors_over != '0))
      else $error("over limit flag without shared count");

   a_over_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_sensors_over <= 3'd4))
      else $error("sensors over count out of range");

endmodule

bind multi_sensor_stats_monitor_unit msmon_checker u_msmon_checker (.*);
